@@ src/hrs_pkg.sv @@
// Shared types, constants and the boundary reset helper for the heart-rate statistics block.
`timescale 1ns / 1ps

package hrs_pkg;

    // Field widths fixed by the request and result formats.
    localparam int RATE_W    = 8;
    localparam int BUCKET_W  = 3;
    localparam int TOTAL_W   = 32;
    localparam int SUM_W     = 32;
    localparam int COUNT_W   = 24;
    localparam int CFG_W     = 32;

    // The divider retires one quotient bit per cycle.
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [RATE_W-1:0]  RATE_MAX  = '1;

    // One request: a sample and the period whose summary is reported.
    typedef struct packed {
        logic [RATE_W-1:0] heart_rate;
        logic              report_period;
    } in_payload_t;

    // One result.
    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic [TOTAL_W-1:0]  bucket_total;
        logic [RATE_W-1:0]   period_minimum;
        logic [RATE_W-1:0]   period_maximum;
        logic [RATE_W-1:0]   period_average;
    } out_payload_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic div_load;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } ctrl_status_t;

    // Reset value of boundary i: 100 + 20*i, capped at 255.
    function automatic logic [RATE_W-1:0] boundary_reset(input int i);
        int v;
        v = 100 + 20 * i;
        if (v > 255)
        begin
            v = 255;
        end
        return RATE_W'(v);
    endfunction

endpackage

@@ src/hrs_regs.sv @@
// Configuration register file holding the histogram bucket boundaries.
`timescale 1ns / 1ps

module hrs_regs
    import hrs_pkg::*;
#(
    parameter int NUM_BOUNDARIES = 4,
    parameter int ADDR_W         = 4
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ADDR_W-1:0]                     paddr,
    input  logic [CFG_W-1:0]                      pwdata,
    output logic [CFG_W-1:0]                      prdata,
    output logic [NUM_BOUNDARIES-1:0][RATE_W-1:0] boundaries
);

    localparam int IDX_W = ADDR_W - 2;

    logic [NUM_BOUNDARIES-1:0][RATE_W-1:0] boundary_reg;
    logic [IDX_W-1:0]                      reg_idx;
    logic                                  idx_valid;
    logic                                  wr_en;

    // Registers sit on 32-bit word addresses.
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign idx_valid = (32'(reg_idx) < 32'(NUM_BOUNDARIES));
    assign wr_en     = psel && penable && pwrite && idx_valid;

    // Boundary registers; writes outside the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BOUNDARIES; i++)
            begin
                boundary_reg[i] <= boundary_reset(i);
            end
        end
        else if (wr_en)
        begin
            boundary_reg[reg_idx] <= pwdata[RATE_W-1:0];
        end
    end

    // Read data, zero for addresses without a register.
    always_comb
    begin
        prdata = '0;
        if (idx_valid)
        begin
            prdata = CFG_W'(boundary_reg[reg_idx]);
        end
    end

    assign boundaries = boundary_reg;

endmodule

@@ src/hrs_datapath.sv @@
// Datapath: histogram, per-period statistics, serial divider and result register.
`timescale 1ns / 1ps

module hrs_datapath
    import hrs_pkg::*;
#(
    parameter int NUM_BOUNDARIES = 4,
    parameter int NUM_PERIODS    = 2
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  in_payload_t                           in_data,
    input  logic [NUM_BOUNDARIES-1:0][RATE_W-1:0] boundaries,
    input  ctrl_cmd_t                             cmd,
    output ctrl_status_t                          status,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output out_payload_t                          out_data
);

    localparam int NUM_BUCKETS = NUM_BOUNDARIES + 1;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int PER_W       = (NUM_PERIODS > 1) ? $clog2(NUM_PERIODS) : 1;

    // Captured request.
    logic [RATE_W-1:0]  rate_reg;
    logic [PER_W-1:0]   sel_reg;
    logic [PER_W-1:0]   sel_next;

    // Histogram and period statistics.
    logic [TOTAL_W-1:0] bucket_count_reg [NUM_BUCKETS];
    logic [RATE_W-1:0]  low_reg          [NUM_PERIODS];
    logic [RATE_W-1:0]  high_reg         [NUM_PERIODS];
    logic [SUM_W-1:0]   sum_reg          [NUM_PERIODS];
    logic [COUNT_W-1:0] count_reg        [NUM_PERIODS];
    logic [RATE_W-1:0]  low_next         [NUM_PERIODS];
    logic [RATE_W-1:0]  high_next        [NUM_PERIODS];
    logic [SUM_W-1:0]   sum_next         [NUM_PERIODS];
    logic [COUNT_W-1:0] count_next       [NUM_PERIODS];

    logic [BKT_W-1:0]   bucket_idx;
    logic [TOTAL_W-1:0] cur_total;
    logic [TOTAL_W-1:0] new_total;

    // Partial result held until the divider finishes.
    logic [BUCKET_W-1:0] res_bucket_reg;
    logic [TOTAL_W-1:0]  res_total_reg;
    logic [RATE_W-1:0]   res_min_reg;
    logic [RATE_W-1:0]   res_max_reg;

    // Restoring divider.
    logic [COUNT_W-1:0] div_rem_reg;
    logic [SUM_W-1:0]   div_quo_reg;
    logic [COUNT_W-1:0] div_den_reg;
    logic               div_zero_reg;
    logic [COUNT_W:0]   div_trial;
    logic [COUNT_W:0]   div_diff;
    logic               div_ge;
    logic [RATE_W-1:0]  average;

    // Output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    out_payload_t       out_data_reg;

    // With a single period, period 0 is used; otherwise the request's period bit is the index.
    always_comb
    begin
        if (NUM_PERIODS > 1)
        begin
            sel_next = PER_W'(in_data.report_period);
        end
        else
        begin
            sel_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rate_reg <= in_data.heart_rate;
            sel_reg  <= sel_next;
        end
    end

    // The first boundary above the sample picks the bucket, else the last bucket.
    always_comb
    begin
        bucket_idx = BKT_W'(NUM_BOUNDARIES);
        for (int b = NUM_BOUNDARIES - 1; b >= 0; b--)
        begin
            if (rate_reg < boundaries[b])
            begin
                bucket_idx = BKT_W'(b);
            end
        end
        cur_total = bucket_count_reg[bucket_idx];
        new_total = (cur_total == TOTAL_MAX) ? cur_total : cur_total + 1'b1;
    end

    // Next statistics of every period; sum and count hold once the count is full.
    always_comb
    begin
        for (int p = 0; p < NUM_PERIODS; p++)
        begin
            logic [SUM_W:0] sum_wide;
            sum_wide      = {1'b0, sum_reg[p]} + (SUM_W + 1)'(rate_reg);
            low_next[p]   = (rate_reg < low_reg[p])  ? rate_reg : low_reg[p];
            high_next[p]  = (rate_reg > high_reg[p]) ? rate_reg : high_reg[p];
            sum_next[p]   = sum_reg[p];
            count_next[p] = count_reg[p];
            if (count_reg[p] != COUNT_MAX)
            begin
                sum_next[p]   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                count_next[p] = count_reg[p] + 1'b1;
            end
        end
    end

    // Architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BUCKETS; b++)
            begin
                bucket_count_reg[b] <= '0;
            end
            for (int p = 0; p < NUM_PERIODS; p++)
            begin
                low_reg[p]   <= RATE_MAX;
                high_reg[p]  <= '0;
                sum_reg[p]   <= '0;
                count_reg[p] <= '0;
            end
        end
        else if (cmd.update)
        begin
            bucket_count_reg[bucket_idx] <= new_total;
            for (int p = 0; p < NUM_PERIODS; p++)
            begin
                low_reg[p]   <= low_next[p];
                high_reg[p]  <= high_next[p];
                sum_reg[p]   <= sum_next[p];
                count_reg[p] <= count_next[p];
            end
        end
    end

    // Bucket and its new total are known after the update.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            res_bucket_reg <= BUCKET_W'(bucket_idx);
            res_total_reg  <= new_total;
        end
        if (cmd.div_load)
        begin
            res_min_reg <= low_reg[sel_reg];
            res_max_reg <= high_reg[sel_reg];
        end
    end

    // One quotient bit per step: shift in the next dividend bit, subtract if it fits.
    assign div_trial = {div_rem_reg, div_quo_reg[SUM_W-1]};
    assign div_diff  = div_trial - {1'b0, div_den_reg};
    assign div_ge    = (div_trial >= {1'b0, div_den_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            div_rem_reg  <= '0;
            div_quo_reg  <= sum_reg[sel_reg];
            div_den_reg  <= count_reg[sel_reg];
            div_zero_reg <= (count_reg[sel_reg] == '0);
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_ge ? div_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
            div_quo_reg <= {div_quo_reg[SUM_W-2:0], div_ge};
        end
    end

    // Empty period averages to zero; a quotient above 255 is clamped.
    always_comb
    begin
        if (div_zero_reg)
        begin
            average = '0;
        end
        else if (|div_quo_reg[SUM_W-1:RATE_W])
        begin
            average = RATE_MAX;
        end
        else
        begin
            average = div_quo_reg[RATE_W-1:0];
        end
    end

    // Result register; it frees when empty or when its result is taken.
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.bucket         <= res_bucket_reg;
            out_data_reg.bucket_total   <= res_total_reg;
            out_data_reg.period_minimum <= res_min_reg;
            out_data_reg.period_maximum <= res_max_reg;
            out_data_reg.period_average <= average;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/hrs_ctrl.sv @@
// Controller state machine sequencing update, division and result hand-off.
`timescale 1ns / 1ps

module hrs_ctrl
    import hrs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_LOAD   = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DIV_STEP_W-1:0] step_next;
    logic                  last_step;

    assign last_step = (step_reg == DIV_STEP_W'(DIV_STEPS - 1));

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (last_step)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.out_load = status.out_free;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ src/heart_rate_statistics.sv @@
// A request is taken while idle; the block then updates the statistics, loads and
// runs the 32-step serial divider, and loads the result register once it is free.
// No new request is taken until the result has been loaded.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n, asynchronous, active low) restores boundaries 100, 120, 140, 160,
// clears histogram, sums and counts, sets minimum to 255 and maximum to 0.
`timescale 1ns / 1ps

module heart_rate_statistics
    import hrs_pkg::*;
#(
    parameter int NUM_BOUNDARIES = 4,
    parameter int NUM_PERIODS    = 2,
    localparam int IDX_W  = (NUM_BOUNDARIES > 1) ? $clog2(NUM_BOUNDARIES) : 1,
    localparam int ADDR_W = IDX_W + 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_payload_t       in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_payload_t      out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    logic [NUM_BOUNDARIES-1:0][RATE_W-1:0] boundaries;
    ctrl_cmd_t                             cmd;
    ctrl_status_t                          status;

    assign pready = 1'b1;

    // Configuration registers.
    hrs_regs #(
        .NUM_BOUNDARIES (NUM_BOUNDARIES),
        .ADDR_W         (ADDR_W)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .boundaries (boundaries)
    );

    // Sequencer.
    hrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Statistics datapath.
    hrs_datapath #(
        .NUM_BOUNDARIES (NUM_BOUNDARIES),
        .NUM_PERIODS    (NUM_PERIODS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_data),
        .boundaries (boundaries),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // A taken request keeps the input stalled while it is worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a request was taken");

    // The result register is only loaded when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending result");

    // A result appears only after a load command.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result valid without a load");

    // Statistics never change while the divider is stepping.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !cmd.update && !cmd.capture)
        else $error("statistics update during division");

endmodule

@@ test/tb_heart_rate_statistics.sv @@
// Self-checking testbench for the heart-rate histogram and period statistics block.
`timescale 1ns / 1ps

module tb_heart_rate_statistics;
    import hrs_pkg::*;

    localparam int NUM_BOUNDARIES   = 4;
    localparam int NUM_PERIODS      = 2;
    localparam int NUM_BUCKETS      = NUM_BOUNDARIES + 1;
    localparam int CFG_ADDR_W       = $clog2(NUM_BOUNDARIES) + 2;
    localparam int REG_STRIDE       = 4;
    localparam int CLK_HALF         = 2;
    localparam int RESET_CYCLES     = 8;
    localparam int DRAIN_CYCLES     = 40;
    localparam int LONG_HOLD        = 300;
    localparam int RANDOM_PHASES    = 6;
    localparam int CHUNKS_PER_PHASE = 6;
    localparam int CHUNK_ITEMS      = 50;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int MAX_REPORTS      = 10;

    // Receiver stall behaviors, switched at random intervals.
    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_CYCLIC} stall_mode_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_payload_t           in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_payload_t          out_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_W-1:0]      pwdata    = '0;
    logic [CFG_W-1:0]      prdata;
    logic                  pready;

    heart_rate_statistics #(
        .NUM_BOUNDARIES(NUM_BOUNDARIES),
        .NUM_PERIODS   (NUM_PERIODS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the block's configuration and statistics.
    logic [RATE_W-1:0]  bound_model  [NUM_BOUNDARIES];
    logic [TOTAL_W-1:0] bucket_model [NUM_BUCKETS];
    logic [RATE_W-1:0]  low_model    [NUM_PERIODS];
    logic [RATE_W-1:0]  high_model   [NUM_PERIODS];
    logic [SUM_W-1:0]   sum_model    [NUM_PERIODS];
    logic [COUNT_W-1:0] count_model  [NUM_PERIODS];

    in_payload_t  sample_queue[$];
    out_payload_t expected_results[$];

    int cycle_count     = 0;
    int accepted_count  = 0;
    int result_count    = 0;
    int mismatch_count  = 0;
    int orphan_results  = 0;
    int register_errors = 0;
    int settings_count  = 0;
    int hold_requests   = 0;
    int holds_served    = 0;
    int bucket_hits [NUM_BUCKETS];

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog: a correct run finishes far below this count.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic in_payload_t make_request(input int rate, input int period);
        in_payload_t req;
        req.heart_rate    = rate[RATE_W-1:0];
        req.report_period = period[0];
        return req;
    endfunction

    // Applies one sample to the shadow statistics and returns the result it should produce.
    function automatic out_payload_t histogram_step(input in_payload_t req);
        out_payload_t     res;
        int               sel;
        int               b;
        logic [SUM_W-1:0] room;
        logic [SUM_W-1:0] avg;
        sel = int'(req.report_period);
        if (sel >= NUM_PERIODS)
        begin
            sel = NUM_PERIODS - 1;
        end
        // First boundary above the sample wins; otherwise the top bucket.
        b = NUM_BOUNDARIES;
        for (int i = NUM_BOUNDARIES - 1; i >= 0; i--)
        begin
            if (req.heart_rate < bound_model[i])
            begin
                b = i;
            end
        end
        if (bucket_model[b] != TOTAL_MAX)
        begin
            bucket_model[b] = bucket_model[b] + 1'b1;
        end
        // Every period sees every sample; sum and count freeze once the count is full.
        for (int p = 0; p < NUM_PERIODS; p++)
        begin
            if (req.heart_rate > high_model[p])
            begin
                high_model[p] = req.heart_rate;
            end
            if (req.heart_rate < low_model[p])
            begin
                low_model[p] = req.heart_rate;
            end
            if (count_model[p] < COUNT_MAX)
            begin
                room = SUM_MAX - sum_model[p];
                sum_model[p] = (room < SUM_W'(req.heart_rate)) ? SUM_MAX
                             : sum_model[p] + SUM_W'(req.heart_rate);
                count_model[p] = count_model[p] + 1'b1;
            end
        end
        if (count_model[sel] != '0)
        begin
            avg = sum_model[sel] / SUM_W'(count_model[sel]);
            if (avg > SUM_W'(RATE_MAX))
            begin
                avg = SUM_W'(RATE_MAX);
            end
        end
        else
        begin
            avg = '0;
        end
        res.bucket         = BUCKET_W'(b);
        res.bucket_total   = bucket_model[b];
        res.period_minimum = low_model[sel];
        res.period_maximum = high_model[sel];
        res.period_average = avg[RATE_W-1:0];
        return res;
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        out_payload_t want;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                want = histogram_step(in_data);
                expected_results.push_back(want);
                bucket_hits[want.bucket]++;
                accepted_count++;
            end
            if (in_valid && in_stall)
            begin
                // A stalled request stays on the bus unchanged.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (sample_queue.size() > 0)
            begin
                in_data  <= sample_queue.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                if (burst_left == 0)
                begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with long hold-offs on request from the stimulus.
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;
    int          cyc_phase  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            mode_left = 0;
        end
        else
        begin
            if (holds_served != hold_requests)
            begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left <= 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(20, 400);
                end
                mode_left--;
                cyc_phase++;
                case (stall_mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_CYCLIC: out_stall <= ((cyc_phase % 7) < 3);
                    default:      out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        out_payload_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                orphan_results++;
                if (orphan_results + mismatch_count <= MAX_REPORTS)
                begin
                    $display("Result %0d arrived with nothing expected", result_count);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.bucket !== want.bucket
                    || out_data.bucket_total !== want.bucket_total
                    || out_data.period_minimum !== want.period_minimum
                    || out_data.period_maximum !== want.period_maximum
                    || out_data.period_average !== want.period_average)
                begin
                    mismatch_count++;
                    if (orphan_results + mismatch_count <= MAX_REPORTS)
                    begin
                        $display("Result %0d: expected bucket %0d total %0d min %0d max %0d avg %0d",
                                 result_count, want.bucket, want.bucket_total,
                                 want.period_minimum, want.period_maximum, want.period_average);
                        $display("Result %0d:   actual bucket %0d total %0d min %0d max %0d avg %0d",
                                 result_count, out_data.bucket, out_data.bucket_total,
                                 out_data.period_minimum, out_data.period_maximum,
                                 out_data.period_average);
                    end
                end
            end
        end
    end

    task automatic model_reset();
        int v;
        for (int i = 0; i < NUM_BOUNDARIES; i++)
        begin
            v = 100 + 20 * i;
            bound_model[i] = (v > 255) ? RATE_MAX : v[RATE_W-1:0];
        end
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            bucket_model[i] = '0;
            bucket_hits[i]  = 0;
        end
        for (int p = 0; p < NUM_PERIODS; p++)
        begin
            low_model[p]   = RATE_MAX;
            high_model[p]  = '0;
            sum_model[p]   = '0;
            count_model[p] = '0;
        end
    endtask

    // Waits until no request is pending and every expected result has arrived.
    task automatic wait_idle();
        @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register transfer: setup cycle, then access until pready.
    task automatic apb_transfer(input bit is_write, input int idx,
                                input logic [CFG_W-1:0] wdata, output logic [CFG_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= CFG_ADDR_W'(idx * REG_STRIDE);
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic readback_boundary(input int idx);
        logic [CFG_W-1:0] word;
        apb_transfer(1'b0, idx, '0, word);
        if (word[RATE_W-1:0] !== bound_model[idx])
        begin
            register_errors++;
            if (register_errors <= MAX_REPORTS)
            begin
                $display("Boundary %0d reads %0d, expected %0d", idx, word[RATE_W-1:0],
                         bound_model[idx]);
            end
        end
    endtask

    // Writes each boundary with junk in the upper data bits and reads it back.
    task automatic program_boundaries(input logic [NUM_BOUNDARIES-1:0][RATE_W-1:0] values);
        logic [CFG_W-1:0] word;
        logic [CFG_W-1:0] unused;
        wait_idle();
        for (int i = 0; i < NUM_BOUNDARIES; i++)
        begin
            word = $urandom();
            word[RATE_W-1:0] = values[i];
            apb_transfer(1'b1, i, word, unused);
            bound_model[i] = values[i];
            readback_boundary(i);
        end
        settings_count++;
        @(negedge clk);
    endtask

    // Stimulus.
    initial
    begin
        int rest_rates [10];
        int odd_rates  [6];
        logic [NUM_BOUNDARIES-1:0][RATE_W-1:0] values;
        int level;
        int pick;
        int rate;

        rest_rates = '{0, 99, 100, 119, 120, 139, 140, 159, 160, 255};
        odd_rates  = '{49, 50, 199, 200, 254, 255};

        model_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset boundaries must read back as the documented defaults.
        for (int i = 0; i < NUM_BOUNDARIES; i++)
        begin
            readback_boundary(i);
        end
        settings_count++;
        @(negedge clk);

        // Directed: both sides of every default boundary, and the rate extremes.
        foreach (rest_rates[i])
        begin
            sample_queue.push_back(make_request(rest_rates[i], i % 2));
        end

        // All boundaries zero: every sample lands in the top bucket.
        program_boundaries('0);
        sample_queue.push_back(make_request(0, 0));
        sample_queue.push_back(make_request(255, 1));
        sample_queue.push_back(make_request(128, 0));

        // All boundaries at the maximum: only 255 reaches the top bucket.
        program_boundaries('1);
        sample_queue.push_back(make_request(254, 1));
        sample_queue.push_back(make_request(255, 0));
        sample_queue.push_back(make_request(0, 1));

        // Unordered boundaries: 200, 50, 255, 0 for boundaries 0 through 3.
        program_boundaries({8'd0, 8'd255, 8'd50, 8'd200});
        foreach (odd_rates[i])
        begin
            sample_queue.push_back(make_request(odd_rates[i], i % 2));
        end

        // Random phases, each under a fresh boundary setting.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            level = $urandom_range(0, 90);
            for (int i = 0; i < NUM_BOUNDARIES; i++)
            begin
                case (ph % 3)
                    0:
                    begin
                        values[i] = (level > 255) ? RATE_MAX : level[RATE_W-1:0];
                        level += $urandom_range(0, 60);
                    end
                    1:
                    begin
                        values[i] = RATE_W'($urandom_range(0, 255));
                    end
                    default:
                    begin
                        pick = $urandom_range(0, 2);
                        values[i] = (pick == 0) ? '0 : (pick == 1) ? RATE_MAX
                                  : RATE_W'($urandom_range(0, 255));
                    end
                endcase
            end
            program_boundaries(values);

            for (int chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++)
            begin
                @(negedge clk);
                // Hold the output off for a long stretch while requests keep coming.
                if ((ph == 0 && chunk == 0) || $urandom_range(0, 11) == 0)
                begin
                    hold_requests++;
                end
                for (int k = 0; k < CHUNK_ITEMS; k++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                    begin
                        rate = $urandom_range(0, 255);
                    end
                    else if (pick < 8)
                    begin
                        // Right at or next to one of the boundaries.
                        rate = int'(bound_model[$urandom_range(0, NUM_BOUNDARIES - 1)])
                             + int'($urandom_range(0, 2)) - 1;
                        if (rate < 0)
                        begin
                            rate = 0;
                        end
                        if (rate > 255)
                        begin
                            rate = 255;
                        end
                    end
                    else
                    begin
                        rate = $urandom_range(45, 190);
                    end
                    sample_queue.push_back(make_request(rate, $urandom_range(0, 1)));
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    wait_idle();
                end
                else
                begin
                    while (sample_queue.size() > 8)
                    begin
                        @(negedge clk);
                    end
                end
            end
        end

        wait_idle();

        $display("Run covered %0d samples under %0d boundary settings with %0d long output holds.",
                 accepted_count, settings_count, hold_requests);
        $display("Samples per bucket: %0d %0d %0d %0d %0d; result errors %0d, register errors %0d.",
                 bucket_hits[0], bucket_hits[1], bucket_hits[2], bucket_hits[3], bucket_hits[4],
                 mismatch_count + orphan_results, register_errors);
        if (mismatch_count == 0 && orphan_results == 0 && register_errors == 0
            && expected_results.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/hrs_pkg.sv
src/hrs_regs.sv
src/hrs_datapath.sv
src/hrs_ctrl.sv
src/heart_rate_statistics.sv
test/tb_heart_rate_statistics.sv
